>>> rtl/core/iwf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iwf_pkg
// Shared widths, constants, command/status types and clamp helpers for the
// iterative wavefolder.
// ----------------------------------------------------------------------------
package iwf_pkg;

    localparam int FRAC_BITS = 12;
    localparam int ONE_V_I   = 1 << FRAC_BITS;
    localparam int MILLI_V_I = (ONE_V_I + 500) / 1000;

    localparam int SAMPLE_W = 17;
    localparam int CV_W     = 17;
    localparam int KNOB_W   = 16;
    localparam int FOLDED_W = 16;
    localparam int EXCESS_W = 18;
    localparam int X_W      = 24;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    localparam logic signed [CV_W-1:0] CV_LO = CV_W'(-MILLI_V_I);
    localparam logic signed [CV_W-1:0] CV_HI = CV_W'(10 * ONE_V_I + MILLI_V_I);
    localparam logic [KNOB_W-1:0]      KNOB_MAX = KNOB_W'(10 * ONE_V_I);

    localparam logic [KNOB_W-1:0] GAIN_KNOB_RST = 16'd819;
    localparam logic [KNOB_W-1:0] FOLD_KNOB_RST = 16'd0;

    localparam logic signed [X_W-1:0] FIVE_V  = X_W'(5 * ONE_V_I);
    localparam logic signed [X_W-1:0] X_LIMIT = X_W'(1 << 22);

    localparam logic [EXCESS_W-1:0] EXC_MAX    = EXCESS_W'(58 * ONE_V_I);
    localparam logic [19:0]         EXC_D_MAX  = 20'd522651;
    localparam logic [22:0]         EXC_RECIP  = 23'd6100806;
    localparam int                  EXC_SHIFT  = 26;
    localparam logic [26:0]         DIV5_RECIP = 27'd107374183;
    localparam int                  DIV5_SHIFT = 29;

    localparam logic [0:0] REG_GAIN_KNOB = 1'b0;
    localparam logic [0:0] REG_FOLD_KNOB = 1'b1;

    typedef struct packed {
        logic load;
        logic mul0;
        logic xinit;
        logic exc_mul;
        logic exc_ld;
        logic refl_mul_a;
        logic refl_mul_b;
        logic refl_upd;
        logic refl_pos;
        logic out_ld;
        logic out_zero;
    } t_cmd;

    typedef struct packed {
        logic x_lt;
        logic x_gt;
    } t_status;

    function automatic logic signed [CV_W-1:0] cv_clamp(input logic signed [CV_W-1:0] v);
        logic signed [CV_W-1:0] r;
        r = v;
        if (v < CV_LO) begin
            r = CV_LO;
        end else if (v > CV_HI) begin
            r = CV_HI;
        end
        return r;
    endfunction

    function automatic logic signed [CV_W-1:0] knob_clamp(input logic [KNOB_W-1:0] k);
        logic signed [CV_W-1:0] r;
        r = $signed({1'b0, k});
        if (k > KNOB_MAX) begin
            r = $signed({1'b0, KNOB_MAX});
        end
        return r;
    endfunction

endpackage

>>> rtl/core/iwf_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iwf_regs
// APB-style register file holding the gain and fold knob values.
// ----------------------------------------------------------------------------
module iwf_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [iwf_pkg::ADDR_W-1:0]   paddr,
    input  logic [iwf_pkg::DATA_W-1:0]   pwdata,
    output logic [iwf_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    output logic [iwf_pkg::KNOB_W-1:0]   o_gain_knob,
    output logic [iwf_pkg::KNOB_W-1:0]   o_fold_knob
);
    import iwf_pkg::*;

    logic [KNOB_W-1:0] r_gain_knob, n_gain_knob;
    logic [KNOB_W-1:0] r_fold_knob, n_fold_knob;
    logic              w_wr;
    logic [0:0]        w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;
    assign w_idx  = paddr[ADDR_W-1 -: 1];

    always_comb begin
        n_gain_knob = r_gain_knob;
        n_fold_knob = r_fold_knob;
        if (w_wr) begin
            case (w_idx)
                REG_GAIN_KNOB: n_gain_knob = pwdata[KNOB_W-1:0];
                REG_FOLD_KNOB: n_fold_knob = pwdata[KNOB_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_GAIN_KNOB: prdata = DATA_W'(r_gain_knob);
            REG_FOLD_KNOB: prdata = DATA_W'(r_fold_knob);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_knob <= GAIN_KNOB_RST;
            r_fold_knob <= FOLD_KNOB_RST;
        end else begin
            r_gain_knob <= n_gain_knob;
            r_fold_knob <= n_fold_knob;
        end
    end

    assign o_gain_knob = r_gain_knob;
    assign o_fold_knob = r_fold_knob;

endmodule

>>> rtl/core/iwf_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iwf_dp
// Wavefolder datapath: gain scaling, drive excess, reflection unit
// (overshoot times fold, reciprocal divide by five volts) and output word.
// ----------------------------------------------------------------------------
module iwf_dp (
    input  logic                                i_clk,
    input  iwf_pkg::t_cmd                       i_cmd,
    output iwf_pkg::t_status                    o_status,
    input  logic signed [iwf_pkg::SAMPLE_W-1:0] i_sample,
    input  logic signed [iwf_pkg::CV_W-1:0]     i_gain_cv,
    input  logic                                i_gain_cv_on,
    input  logic signed [iwf_pkg::CV_W-1:0]     i_fold_cv,
    input  logic                                i_fold_cv_on,
    input  logic [iwf_pkg::KNOB_W-1:0]          i_gain_knob,
    input  logic [iwf_pkg::KNOB_W-1:0]          i_fold_knob,
    output logic signed [iwf_pkg::FOLDED_W-1:0] o_folded,
    output logic [iwf_pkg::EXCESS_W-1:0]        o_drive_excess
);
    import iwf_pkg::*;

    logic signed [SAMPLE_W-1:0] r_sample;
    logic signed [CV_W-1:0]     r_gain;
    logic signed [CV_W-1:0]     r_fold;
    logic signed [33:0]         r_prod0;
    logic signed [X_W-1:0]      r_x;
    logic [44:0]                r_eprod;
    logic                       r_egt;
    logic [EXCESS_W-1:0]        r_excess;
    logic signed [39:0]         r_rprod;
    logic [52:0]                r_qprod;
    logic                       r_qneg;
    logic signed [FOLDED_W-1:0] r_folded;
    logic [EXCESS_W-1:0]        r_dexc;

    // initial scaling: x = round(sample * 5 * gain / 1 V)
    logic signed [36:0]    w_p5;
    logic [35:0]           w_p5_mag;
    logic [35:0]           w_x0_mag;
    logic signed [X_W-1:0] w_x0;

    assign w_p5     = (37'(r_prod0) <<< 2) + 37'(r_prod0);
    assign w_p5_mag = w_p5[36] ? 36'(-w_p5) : 36'(w_p5);
    assign w_x0_mag = (w_p5_mag + 36'(ONE_V_I / 2)) >> FRAC_BITS;
    assign w_x0     = w_p5[36] ? -$signed({1'b0, w_x0_mag[X_W-2:0]})
                               :  $signed({1'b0, w_x0_mag[X_W-2:0]});

    // drive excess: floor((5d + 5) / 11) by reciprocal
    logic [X_W-2:0] w_ax;
    logic           w_gt5;
    logic [X_W-2:0] w_d;
    logic [19:0]    w_dsat;
    logic [21:0]    w_m;
    logic [18:0]    w_eq;

    assign w_ax   = r_x[X_W-1] ? (X_W-1)'(-r_x) : (X_W-1)'(r_x);
    assign w_gt5  = w_ax > (X_W-1)'(FIVE_V);
    assign w_d    = w_ax - (X_W-1)'(FIVE_V);
    assign w_dsat = (w_d > (X_W-1)'(EXC_D_MAX)) ? EXC_D_MAX : w_d[19:0];
    assign w_m    = 22'({w_dsat, 2'b00}) + 22'(w_dsat) + 22'd5;
    assign w_eq   = r_eprod[EXC_SHIFT +: 19];

    // reflection unit
    logic signed [X_W:0]   w_over;
    logic [21:0]           w_o;
    logic [38:0]           w_rmag;
    logic [25:0]           w_n;
    logic [22:0]           w_q;
    logic signed [24:0]    w_r;
    logic signed [25:0]    w_xn;
    logic signed [X_W-1:0] w_xc;

    assign w_over = i_cmd.refl_pos ? ((X_W+1)'(r_x) - (X_W+1)'(FIVE_V))
                                   : (-(X_W+1)'(r_x) - (X_W+1)'(FIVE_V));
    assign w_o    = w_over[21:0];
    assign w_rmag = r_rprod[39] ? 39'(-r_rprod) : 39'(r_rprod);
    assign w_n    = 26'((w_rmag + 39'(5 * ONE_V_I / 2)) >> FRAC_BITS);
    assign w_q    = r_qprod[DIV5_SHIFT +: 23];
    assign w_r    = r_qneg ? -$signed({2'b00, w_q}) : $signed({2'b00, w_q});
    assign w_xn   = i_cmd.refl_pos ? (26'(FIVE_V) - 26'(w_r)) : (26'(w_r) - 26'(FIVE_V));

    always_comb begin
        if (w_xn > 26'(X_LIMIT)) begin
            w_xc = X_LIMIT;
        end else if (w_xn < -26'(X_LIMIT)) begin
            w_xc = -X_LIMIT;
        end else begin
            w_xc = w_xn[X_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_sample;
            r_gain   <= i_gain_cv_on ? cv_clamp(i_gain_cv) : knob_clamp(i_gain_knob);
            r_fold   <= i_fold_cv_on ? cv_clamp(i_fold_cv) : knob_clamp(i_fold_knob);
        end
        if (i_cmd.mul0) begin
            r_prod0 <= r_sample * r_gain;
        end
        if (i_cmd.xinit) begin
            r_x <= w_x0;
        end else if (i_cmd.refl_upd) begin
            r_x <= w_xc;
        end
        if (i_cmd.exc_mul) begin
            r_eprod <= 45'(w_m) * 45'(EXC_RECIP);
            r_egt   <= w_gt5;
        end
        if (i_cmd.exc_ld) begin
            if (!r_egt) begin
                r_excess <= '0;
            end else if (w_eq > 19'(EXC_MAX)) begin
                r_excess <= EXC_MAX;
            end else begin
                r_excess <= w_eq[EXCESS_W-1:0];
            end
        end
        if (i_cmd.refl_mul_a) begin
            r_rprod <= $signed({1'b0, w_o}) * r_fold;
        end
        if (i_cmd.refl_mul_b) begin
            r_qprod <= 53'(w_n) * 53'(DIV5_RECIP);
            r_qneg  <= r_rprod[39];
        end
        if (i_cmd.out_ld) begin
            r_folded <= i_cmd.out_zero ? '0 : r_x[FOLDED_W-1:0];
            r_dexc   <= r_excess;
        end
    end

    assign o_status.x_lt  = r_x < -FIVE_V;
    assign o_status.x_gt  = r_x > FIVE_V;
    assign o_folded       = r_folded;
    assign o_drive_excess = r_dexc;

endmodule

>>> rtl/core/iwf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iwf_ctrl
// Sequencer for the wavefolder: input handshake, scaling steps, the fold
// pass loop with its pass counter, and the output word handshake.
// ----------------------------------------------------------------------------
module iwf_ctrl #(
    parameter int MAX_FOLDS = 100
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  iwf_pkg::t_status i_status,
    output iwf_pkg::t_cmd    o_cmd
);
    import iwf_pkg::*;

    localparam int PW = (MAX_FOLDS > 1) ? $clog2(MAX_FOLDS) : 1;
    localparam logic [PW-1:0] LAST_PASS = PW'(MAX_FOLDS - 1);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_MUL0   = 10'b0000000010,
        S_XINIT  = 10'b0000000100,
        S_EXC    = 10'b0000001000,
        S_EXCW   = 10'b0000010000,
        S_DECIDE = 10'b0000100000,
        S_MULA   = 10'b0001000000,
        S_MULB   = 10'b0010000000,
        S_UPD    = 10'b0100000000,
        S_OUT    = 10'b1000000000
    } t_state;

    typedef enum logic [1:0] {
        STG_START    = 2'd0,
        STG_NEG_DONE = 2'd1,
        STG_POS_DONE = 2'd2
    } t_stage;

    t_state        r_state, n_state;
    t_stage        r_stage, n_stage;
    logic [PW-1:0] r_pass, n_pass;
    logic          r_pos, n_pos;
    logic          r_inside, n_inside;
    logic          r_out_valid, n_out_valid;

    // decision for one look at x
    logic w_go, w_go_pos, w_fin, w_fin_in, w_step;
    logic w_in_range;

    assign w_in_range = !i_status.x_lt && !i_status.x_gt;

    always_comb begin
        w_go     = 1'b0;
        w_go_pos = 1'b0;
        w_fin    = 1'b0;
        w_fin_in = 1'b0;
        w_step   = 1'b0;
        case (r_stage)
            STG_START: begin
                if (w_in_range) begin
                    w_fin    = 1'b1;
                    w_fin_in = 1'b1;
                end else begin
                    w_go     = 1'b1;
                    w_go_pos = i_status.x_gt;
                end
            end
            STG_NEG_DONE, STG_POS_DONE: begin
                if (r_stage == STG_NEG_DONE && i_status.x_gt) begin
                    w_go     = 1'b1;
                    w_go_pos = 1'b1;
                end else if (w_in_range) begin
                    w_fin    = 1'b1;
                    w_fin_in = 1'b1;
                end else if (r_pass == LAST_PASS) begin
                    w_fin = 1'b1;
                end else begin
                    // next pass starts right away
                    w_step   = 1'b1;
                    w_go     = 1'b1;
                    w_go_pos = i_status.x_gt;
                end
            end
            default: begin
                w_fin = 1'b1;
            end
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_stage  = r_stage;
        n_pass   = r_pass;
        n_pos    = r_pos;
        n_inside = r_inside;
        o_cmd    = '0;
        o_cmd.refl_pos = r_pos;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_pass     = '0;
                    n_stage    = STG_START;
                    n_state    = S_MUL0;
                end
            end
            S_MUL0: begin
                o_cmd.mul0 = 1'b1;
                n_state    = S_XINIT;
            end
            S_XINIT: begin
                o_cmd.xinit = 1'b1;
                n_state     = S_EXC;
            end
            S_EXC: begin
                o_cmd.exc_mul = 1'b1;
                n_state       = S_EXCW;
            end
            S_EXCW: begin
                o_cmd.exc_ld = 1'b1;
                n_state      = S_DECIDE;
            end
            S_DECIDE: begin
                if (w_step) begin
                    n_pass = r_pass + 1'b1;
                end
                if (w_go) begin
                    n_pos   = w_go_pos;
                    n_state = S_MULA;
                end else if (w_fin) begin
                    n_inside = w_fin_in;
                    n_state  = S_OUT;
                end
            end
            S_MULA: begin
                o_cmd.refl_mul_a = 1'b1;
                n_state          = S_MULB;
            end
            S_MULB: begin
                o_cmd.refl_mul_b = 1'b1;
                n_state          = S_UPD;
            end
            S_UPD: begin
                o_cmd.refl_upd = 1'b1;
                n_stage        = r_pos ? STG_POS_DONE : STG_NEG_DONE;
                n_state        = S_DECIDE;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_ld   = 1'b1;
                    o_cmd.out_zero = !r_inside;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = o_cmd.out_ld | (r_out_valid & ~i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_stage     <= STG_START;
            r_pass      <= '0;
            r_pos       <= 1'b0;
            r_inside    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_stage     <= n_stage;
            r_pass      <= n_pass;
            r_pos       <= n_pos;
            r_inside    <= n_inside;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/core/iterative_wavefolder_with_gain.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iterative_wavefolder_with_gain
// Wavefolder with gain and fold controls, knob registers on an APB-style port.
// ----------------------------------------------------------------------------
// Each input word is scaled by five times the gain, its drive excess is
// reported, and it is then folded by repeated reflection about +-5 V until it
// lies inside that range (0 if it does not settle within MAX_FOLDS passes).
// One word is processed at a time: the input is ready again only once the word
// has passed load, scaling, the drive excess steps, a decision and the output
// load. Each reflection adds a decision step and the steps through the
// shared multiply chain: overshoot times fold, reciprocal divide by five
// volts, update. A pass holds at most two reflections. A finished word waits
// in the output register while the next input word is taken and worked on.
// ----------------------------------------------------------------------------
module iterative_wavefolder_with_gain #(
    parameter int MAX_FOLDS = 100
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [iwf_pkg::SAMPLE_W-1:0] i_sample,
    input  logic signed [iwf_pkg::CV_W-1:0]     i_gain_cv,
    input  logic                                i_gain_cv_on,
    input  logic signed [iwf_pkg::CV_W-1:0]     i_fold_cv,
    input  logic                                i_fold_cv_on,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [iwf_pkg::FOLDED_W-1:0] o_folded,
    output logic [iwf_pkg::EXCESS_W-1:0]        o_drive_excess,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [iwf_pkg::ADDR_W-1:0]          paddr,
    input  logic [iwf_pkg::DATA_W-1:0]          pwdata,
    output logic [iwf_pkg::DATA_W-1:0]          prdata,
    output logic                                pready
);
    import iwf_pkg::*;

    t_cmd              w_cmd;
    t_status           w_status;
    logic [KNOB_W-1:0] w_gain_knob;
    logic [KNOB_W-1:0] w_fold_knob;

    iwf_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_gain_knob (w_gain_knob),
        .o_fold_knob (w_fold_knob)
    );

    iwf_ctrl #(
        .MAX_FOLDS (MAX_FOLDS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    iwf_dp u_dp (
        .i_clk          (i_clk),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_sample       (i_sample),
        .i_gain_cv      (i_gain_cv),
        .i_gain_cv_on   (i_gain_cv_on),
        .i_fold_cv      (i_fold_cv),
        .i_fold_cv_on   (i_fold_cv_on),
        .i_gain_knob    (w_gain_knob),
        .i_fold_knob    (w_fold_knob),
        .o_folded       (o_folded),
        .o_drive_excess (o_drive_excess)
    );

endmodule
